// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Constants, types and codes shared by the cache model modules.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int SETS      = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W      = $clog2(MAX_WAYS + 1);
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W     = 64;
    localparam int CNT_W     = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic hit;
        logic evict;
    } access_t;

endpackage

`default_nettype wire

// File: src/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/salc_update.sv
// ----------------------------------------------------------------------------
// salc_update
// Tag compare across the ways of one set, victim choice and recency update.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_update (
    input  wire logic                                row_ok,
    input  wire salc_pkg::row_t                      row_in,
    input  wire logic [salc_pkg::TAG_W-1:0]          tag,
    input  wire logic [salc_pkg::NW_W-1:0]           nw,
    output salc_pkg::row_t                           row_out,
    output salc_pkg::access_t                        result
);

    logic [salc_pkg::MAX_WAYS-1:0] in_way;
    logic [salc_pkg::MAX_WAYS-1:0] vld;
    logic [salc_pkg::MAX_WAYS-1:0] hitv;
    logic [salc_pkg::RANK_W-1:0]   rank [salc_pkg::MAX_WAYS];
    logic                          hit;
    logic                          found;
    logic [salc_pkg::WAY_W-1:0]    hit_way;
    logic [salc_pkg::WAY_W-1:0]    free_way;
    logic [salc_pkg::WAY_W-1:0]    lru_way;
    logic [salc_pkg::WAY_W-1:0]    target;
    logic [salc_pkg::RANK_W-1:0]   hit_rank;
    logic [salc_pkg::RANK_W-1:0]   lru_rank;
    logic [salc_pkg::RANK_W:0]     r_eff;

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        hit_rank = '0;
        for (int w = 0; w < salc_pkg::MAX_WAYS; w++)
        begin
            in_way[w] = (salc_pkg::NW_W'(w) < nw);
            vld[w]    = row_ok && row_in[w].valid && in_way[w];
            rank[w]   = row_ok ? row_in[w].rank : '0;
            hitv[w]   = vld[w] && (row_in[w].tag == tag);
            if (hitv[w])
            begin
                hit      = 1'b1;
                hit_way  = salc_pkg::WAY_W'(w);
                hit_rank = rank[w];
            end
        end
    end

    always_comb
    begin
        found    = 1'b0;
        free_way = '0;
        for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--)
        begin
            if (in_way[w] && !vld[w])
            begin
                found    = 1'b1;
                free_way = salc_pkg::WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        lru_way  = '0;
        lru_rank = rank[0];
        for (int w = 1; w < salc_pkg::MAX_WAYS; w++)
        begin
            if (in_way[w] && (rank[w] > lru_rank))
            begin
                lru_way  = salc_pkg::WAY_W'(w);
                lru_rank = rank[w];
            end
        end
    end

    always_comb
    begin
        if (hit)
        begin
            target = hit_way;
            r_eff  = {1'b0, hit_rank};
        end
        else if (found)
        begin
            target = free_way;
            r_eff  = {1'b1, {salc_pkg::RANK_W{1'b0}}};
        end
        else
        begin
            target = lru_way;
            r_eff  = {1'b0, lru_rank};
        end

        for (int w = 0; w < salc_pkg::MAX_WAYS; w++)
        begin
            row_out[w].valid = row_ok && row_in[w].valid;
            row_out[w].rank  = rank[w];
            row_out[w].tag   = row_in[w].tag;
            if (salc_pkg::WAY_W'(w) == target)
            begin
                row_out[w].valid = 1'b1;
                row_out[w].rank  = '0;
                row_out[w].tag   = tag;
            end
            else if (vld[w] && ({1'b0, rank[w]} < r_eff))
            begin
                row_out[w].rank = rank[w] + 1'b1;
            end
        end

        result.hit   = hit;
        result.evict = !hit && !found;
    end

endmodule

`default_nettype wire

// File: src/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache model with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready) carries one access: op and address.
//   The output channel (out_valid, out_ready) carries one result per input:
//   this input's hits, miss and eviction, and the saturating running totals.
//   Each set lives in one row of a RAM; a transfer reads the row, the next
//   cycle compares all ways, writes the row back and loads the output
//   register, which raises out_valid. No new input is taken while an access
//   is in its lookup, set by the read and write-back of the single RAM row
//   per access. A stalled receiver holds the result in the output register,
//   and no new input is taken until that result transfer takes place.
//   Reset clears all lines, the totals and the registers to set_bits 0,
//   block_bits 4 and ways 1. Lines are cleared by per-set valid flops at
//   once, with no clearing pass. A configuration write (cfg_we, cfg_index,
//   cfg_data) to a known register flushes all lines and keeps the totals;
//   the user must make it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_model (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       hits,
    output logic             missed,
    output logic             evicted,
    output logic [31:0]      hit_total,
    output logic [31:0]      miss_total,
    output logic [31:0]      evict_total
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    localparam logic [salc_pkg::CNT_W-1:0] CNT_MAX = '1;

    state_t                           state_reg, state_next;
    logic [2:0]                       set_bits_reg;
    logic [5:0]                       block_bits_reg;
    logic [3:0]                       ways_reg;
    logic [salc_pkg::SETS-1:0]        row_ok_reg;
    logic [1:0]                       op_reg;
    logic [salc_pkg::TAG_W-1:0]       tag_reg;
    logic [salc_pkg::SET_IDX_W-1:0]   set_reg;
    logic                             out_valid_reg;
    logic [1:0]                       hits_reg;
    logic                             missed_reg;
    logic                             evicted_reg;
    logic [salc_pkg::CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [salc_pkg::CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [salc_pkg::CNT_W-1:0]       evict_cnt_reg, evict_cnt_next;

    logic                             in_xfer;
    logic                             cfg_hit;
    logic [2:0]                       sb;
    logic [6:0]                       shift;
    logic [salc_pkg::TAG_W-1:0]       tag_in;
    logic [salc_pkg::SET_IDX_W-1:0]   set_mask;
    logic [salc_pkg::SET_IDX_W-1:0]   set_in;
    logic [salc_pkg::NW_W-1:0]        nw;
    salc_pkg::row_t                   row_rd;
    salc_pkg::row_t                   row_wr;
    salc_pkg::access_t                acc;
    logic                             do_access;
    logic                             ram_we;
    logic [1:0]                       hits_new;
    logic                             missed_new;
    logic                             evicted_new;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer   = in_valid && in_ready;
    assign do_access = (op_reg != salc_pkg::OP_NONE);
    assign ram_we    = (state_reg == ST_LOOKUP) && do_access;

    always_comb
    begin
        if (32'(set_bits_reg) > salc_pkg::MAX_SET_BITS)
        begin
            sb = 3'(salc_pkg::MAX_SET_BITS);
        end
        else
        begin
            sb = set_bits_reg;
        end
        if (ways_reg == 4'd0)
        begin
            nw = salc_pkg::NW_W'(1);
        end
        else if (32'(ways_reg) > salc_pkg::MAX_WAYS)
        begin
            nw = salc_pkg::NW_W'(salc_pkg::MAX_WAYS);
        end
        else
        begin
            nw = salc_pkg::NW_W'(ways_reg);
        end
        shift    = {4'd0, sb} + {1'b0, block_bits_reg};
        tag_in   = (shift >= 7'd64) ? '0 : (address >> shift);
        set_mask = salc_pkg::SET_IDX_W'((32'd1 << sb) - 32'd1);
        set_in   = salc_pkg::SET_IDX_W'(address >> block_bits_reg) & set_mask;
    end

    salc_ram #(
        .WIDTH (salc_pkg::ROW_W),
        .DEPTH (salc_pkg::SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_wr),
        .raddr (set_in),
        .rdata (row_rd)
    );

    salc_update u_update (
        .row_ok  (row_ok_reg[set_reg]),
        .row_in  (row_rd),
        .tag     (tag_reg),
        .nw      (nw),
        .row_out (row_wr),
        .result  (acc)
    );

    always_comb
    begin
        hits_new    = '0;
        missed_new  = 1'b0;
        evicted_new = 1'b0;
        if (do_access)
        begin
            hits_new    = {1'b0, acc.hit} + {1'b0, (op_reg == salc_pkg::OP_MODIFY)};
            missed_new  = !acc.hit;
            evicted_new = acc.evict;
        end
        if ({1'b0, hit_cnt_reg} + 33'(hits_new) > {1'b0, CNT_MAX})
        begin
            hit_cnt_next = CNT_MAX;
        end
        else
        begin
            hit_cnt_next = hit_cnt_reg + salc_pkg::CNT_W'(hits_new);
        end
        if (missed_new && (miss_cnt_reg != CNT_MAX))
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
        end
        else
        begin
            miss_cnt_next = miss_cnt_reg;
        end
        if (evicted_new && (evict_cnt_reg != CNT_MAX))
        begin
            evict_cnt_next = evict_cnt_reg + 1'b1;
        end
        else
        begin
            evict_cnt_next = evict_cnt_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (cfg_index)
            salc_pkg::CFG_SET_BITS,
            salc_pkg::CFG_BLOCK_BITS,
            salc_pkg::CFG_WAYS:
            begin
                cfg_hit = cfg_we;
            end
            default:
            begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            set_bits_reg   <= 3'd0;
            block_bits_reg <= 6'd4;
            ways_reg       <= 4'd1;
            row_ok_reg     <= '0;
            out_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == salc_pkg::CFG_SET_BITS))
            begin
                set_bits_reg <= cfg_data[2:0];
            end
            if (cfg_we && (cfg_index == salc_pkg::CFG_BLOCK_BITS))
            begin
                block_bits_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == salc_pkg::CFG_WAYS))
            begin
                ways_reg <= cfg_data[3:0];
            end
            if (cfg_hit)
            begin
                row_ok_reg <= '0;
            end
            else if (ram_we)
            begin
                row_ok_reg[set_reg] <= 1'b1;
            end
            if (state_reg == ST_LOOKUP)
            begin
                out_valid_reg <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= op;
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hits_reg    <= hits_new;
            missed_reg  <= missed_new;
            evicted_reg <= evicted_new;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hits        = hits_reg;
    assign missed      = missed_reg;
    assign evicted     = evicted_reg;
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;
    assign evict_total = evict_cnt_reg;

endmodule

`default_nettype wire

// File: src/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module salc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  hits,
    input wire logic        missed,
    input wire logic        evicted,
    input wire logic [31:0] hit_total,
    input wire logic [31:0] miss_total,
    input wire logic [31:0] evict_total
);

    `ASSERT_IMP(a_miss_hits, clk, rst_n, out_valid && missed, hits != 2'd2)
    `ASSERT_IMP(a_evict_miss, clk, rst_n, out_valid && evicted, missed)
    `ASSERT_IMP(a_hits_range, clk, rst_n, out_valid, hits != 2'd3)
    `ASSERT_NEXT(a_one_per_two, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(hit_total) && $stable(miss_total) && $stable(evict_total))

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (.*);

`default_nettype wire
